/* hdl/cicp_pkg.sv */
// Shared types, constants and helper functions for the cascaded interrupt controller pair.
`default_nettype none
package cicp_pkg;
	typedef enum logic [1:0] {
		CMD_LINE  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_ACK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_UNSUPPORTED = 2'd1,
		ST_INVALID     = 2'd2,
		ST_UNMAPPED    = 2'd3
	} status_t;

	localparam logic [1:0] REG_MASTER_BASE  = 2'd0;
	localparam logic [1:0] REG_SLAVE_BASE   = 2'd1;
	localparam logic [1:0] REG_CASCADE_LINE = 2'd2;

	localparam logic [15:0] MASTER_BASE_RST  = 16'h0020;
	localparam logic [15:0] SLAVE_BASE_RST   = 16'h00A0;
	localparam logic [2:0]  CASCADE_LINE_RST = 3'd2;

	localparam logic [3:0] NO_LINE = 4'd8;

	typedef struct packed {
		logic [7:0] irr;
		logic [7:0] isr;
		logic [7:0] imr;
		logic [7:0] last;
		logic [7:0] vbase;
		logic [7:0] ident;
		logic [2:0] step;
		logic       single;
		logic       level;
		logic       aeoi;
		logic       raeoi;
		logic [2:0] lowp;
		logic       rsel;
		logic       smm;
		logic       rdy;
		logic [7:0] ext;
		logic [3:0] sel;
	} unit_t;

	typedef struct packed {
		logic       found;
		logic [2:0] line;
	} hit_t;

	function automatic unit_t unit_reset();
		unit_t u;
		u = '0;
		u.imr   = 8'hFF;
		u.ident = 8'd7;
		u.lowp  = 3'd7;
		u.sel   = NO_LINE;
		return u;
	endfunction

	// Highest-priority set bit in rotating order, optionally stopped by a
	// blocking in-service bit met first.
	function automatic hit_t scan(input logic [2:0] lowp, input logic [7:0] req,
		input logic [7:0] blk);
		hit_t h;
		logic stop;
		logic [2:0] ln;
		h = '0;
		stop = 1'b0;
		for (int i = 1; i <= 8; i++) begin
			ln = lowp + 3'(i);
			if (!stop && !h.found) begin
				if (blk[ln]) stop = 1'b1;
				else if (req[ln]) begin
					h.found = 1'b1;
					h.line = ln;
				end
			end
		end
		return h;
	endfunction

	function automatic hit_t pending(input unit_t u);
		hit_t h;
		logic [7:0] act;
		act = u.smm ? (u.isr & ~u.imr) : u.isr;
		h = scan(u.lowp, u.irr & ~u.imr, act);
		if (!u.rdy) h = '0;
		return h;
	endfunction

	function automatic unit_t capture(input unit_t u, input logic [7:0] lines);
		unit_t r;
		r = u;
		if (u.level) r.irr = lines;
		else r.irr = (u.irr | (lines & ~u.last)) & lines;
		r.last = lines;
		return r;
	endfunction
endpackage
`default_nettype wire

/* hdl/cascaded_interrupt_controller_pair.sv */
// Top level: master and slave interrupt controllers with a registered result word.
// The result word of an accepted word is registered and shows in the cycle after it is accepted.
// Throughput: one word per cycle while out_ready is high; the state update is one pass of short logic
// (rotating priority scans over eight lines) between the input and the result register.
// The result register takes a new word whenever it is empty or being taken.
// Reset (arst_n low, asynchronous) restores both units, the cascade and base registers.
`default_nettype none
module cascaded_interrupt_controller_pair (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic [3:0]  irq_number,
	input  wire logic        asserted,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_data,
	input  wire logic        debug_access,
	input  wire logic        ack_phase,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [7:0]       read_data,
	output logic [7:0]       vector_out,
	output logic             vector_valid,
	output logic             interrupt_request
);
	logic [15:0] mbase_q, sbase_q;
	logic [2:0]  cline_q;
	cicp_pkg::unit_t m_q, s_q, m_d, s_d;
	logic ackp_q, ackp_d, intr_q, intr_d;
	logic [7:0] lvec_q, lvec_d;
	logic [1:0] st_d;
	logic [7:0] rd_d, vec_d;
	logic vv_d;
	logic take;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready;
	assign take      = in_valid && in_ready;

	// Runs the line capture of both units and recomputes INTR.
	function automatic void eval_all(inout cicp_pkg::unit_t m, inout cicp_pkg::unit_t s,
		input logic ackp, input logic [2:0] cl, output logic intr);
		logic [7:0] ml;
		cicp_pkg::hit_t h;
		ml = m.ext;
		s = cicp_pkg::capture(s, s.ext);
		h = cicp_pkg::pending(s);
		if (h.found && !(ackp && s.sel != cicp_pkg::NO_LINE)) ml[cl] = 1'b1;
		m = cicp_pkg::capture(m, ml);
		h = cicp_pkg::pending(m);
		intr = !ackp && h.found;
	endfunction

	// One byte written to a unit's port; returns the status.
	function automatic logic [1:0] wr_unit(inout cicp_pkg::unit_t u, input logic data,
		input logic [7:0] v);
		logic [7:0] act;
		logic [2:0] op;
		cicp_pkg::hit_t h;
		logic [2:0] ln;
		logic [7:0] keep;
		wr_unit = cicp_pkg::ST_OK;
		act = u.smm ? (u.isr & ~u.imr) : u.isr;
		op = v[7:5];
		if (!data && v[4]) begin
			if (!v[0]) wr_unit = cicp_pkg::ST_UNSUPPORTED;
			else begin
				keep = u.last;
				u = cicp_pkg::unit_reset();
				u.last = keep;
				u.ext = 8'h00;
				u.imr = 8'h00;
				u.single = v[1];
				u.level = v[3];
				u.step = 3'd2;
			end
		end else if (data && u.step == 3'd2) begin
			u.vbase = v & 8'hF8;
			u.step = u.single ? 3'd4 : 3'd3;
		end else if (data && u.step == 3'd3) begin
			u.ident = v;
			u.step = 3'd4;
		end else if (data && u.step == 3'd4) begin
			if (!v[0] || (v & 8'hF8) != 8'h00) wr_unit = cicp_pkg::ST_UNSUPPORTED;
			else begin
				u.aeoi = v[1];
				u.step = 3'd0;
				u.rdy = 1'b1;
			end
		end else if (!u.rdy) wr_unit = cicp_pkg::ST_INVALID;
		else if (data) u.imr = v;
		else if (v[3]) begin
			if (v[2]) wr_unit = cicp_pkg::ST_UNSUPPORTED;
			else begin
				if (v[6]) u.smm = v[5];
				if (v[1]) u.rsel = v[0];
			end
		end else begin
			if (op == 3'd0) u.raeoi = 1'b0;
			else if (op == 3'd4) u.raeoi = 1'b1;
			else if (op == 3'd6) u.lowp = v[2:0];
			else if (op[0]) begin
				h = cicp_pkg::scan(u.lowp, act, 8'h00);
				if (op[1]) begin
					h.found = 1'b1;
					h.line = v[2:0];
				end
				ln = h.line;
				if (h.found) begin
					u.isr[ln] = 1'b0;
					if (op[2]) u.lowp = ln;
				end
			end
		end
	endfunction

	always_comb begin
		cicp_pkg::unit_t m, s, tm;
		cicp_pkg::hit_t hm, hs;
		logic ackp, intr, casc, hit_m, hit_s, off, ext_keep_m, ext_keep_s;
		logic [2:0] mline;
		logic [7:0] lvec, ext_m, ext_s;
		logic [1:0] st;
		logic [16:0] mtop, stop;
		m = m_q;
		s = s_q;
		tm = m_q;
		ackp = ackp_q;
		intr = intr_q;
		lvec = lvec_q;
		st = cicp_pkg::ST_OK;
		rd_d = 8'h00;
		vec_d = 8'h00;
		vv_d = 1'b0;
		casc = 1'b0;
		hs = '0;
		ext_keep_m = 1'b0;
		ext_keep_s = 1'b0;
		mtop = {1'b0, mbase_q} + 17'd1;
		stop = {1'b0, sbase_q} + 17'd1;
		hit_m = ({1'b0, address} >= {1'b0, mbase_q}) && ({1'b0, address} <= mtop);
		hit_s = ({1'b0, address} >= {1'b0, sbase_q}) && ({1'b0, address} <= stop);
		off = hit_m ? (address != mbase_q) : (address != sbase_q);
		hm = cicp_pkg::pending(m);
		mline = hm.found ? hm.line : 3'd7;
		ext_m = m.ext;
		ext_s = s.ext;
		unique case (cicp_pkg::cmd_t'(command))
			cicp_pkg::CMD_LINE: begin
				if (irq_number[3]) s.ext[irq_number[2:0]] = asserted;
				else m.ext[irq_number[2:0]] = asserted;
				eval_all(m, s, ackp, cline_q, intr);
			end
			cicp_pkg::CMD_ACK: begin
				if (ack_phase != ackp || !m.rdy) st = cicp_pkg::ST_INVALID;
				else if (!ack_phase) begin
					casc = !m.single && m.ident[mline];
					if (casc && (mline != cline_q || !s.rdy || s.single ||
						s.ident[2:0] != mline)) st = cicp_pkg::ST_UNSUPPORTED;
					else begin
						if (casc) hs = cicp_pkg::pending(s);
						m.sel = hm.found ? {1'b0, hm.line} : cicp_pkg::NO_LINE;
						s.sel = (casc && hs.found) ? {1'b0, hs.line} : cicp_pkg::NO_LINE;
						if (casc) lvec = s.vbase + (hs.found ? {5'd0, hs.line} : 8'd7);
						else lvec = m.vbase + {5'd0, mline};
						if (hm.found) begin
							m.irr[hm.line] = 1'b0;
							m.isr[hm.line] = 1'b1;
						end
						if (casc && hs.found) begin
							s.irr[hs.line] = 1'b0;
							s.isr[hs.line] = 1'b1;
						end
						ackp = 1'b1;
						eval_all(m, s, ackp, cline_q, intr);
					end
				end else begin
					vec_d = lvec;
					vv_d = 1'b1;
					if (m.sel != cicp_pkg::NO_LINE && m.aeoi) begin
						m.isr[m.sel[2:0]] = 1'b0;
						if (m.raeoi) m.lowp = m.sel[2:0];
					end
					if (s.sel != cicp_pkg::NO_LINE && s.aeoi) begin
						s.isr[s.sel[2:0]] = 1'b0;
						if (s.raeoi) s.lowp = s.sel[2:0];
					end
					ackp = 1'b0;
					eval_all(m, s, ackp, cline_q, intr);
				end
			end
			default: begin
				if (!hit_m && !hit_s) st = cicp_pkg::ST_UNMAPPED;
				else if (command == cicp_pkg::CMD_READ) begin
					tm = hit_m ? m : s;
					rd_d = off ? tm.imr : (tm.rsel ? tm.isr : tm.irr);
				end else if (debug_access) st = cicp_pkg::ST_UNSUPPORTED;
				else if (ackp) st = cicp_pkg::ST_INVALID;
				else begin
					tm = hit_m ? m : s;
					st = wr_unit(tm, off, write_data);
					// Initialization keeps the external line levels.
					tm.ext = hit_m ? ext_m : ext_s;
					ext_keep_m = hit_m;
					ext_keep_s = !hit_m;
					if (st == cicp_pkg::ST_OK) begin
						if (ext_keep_m) m = tm;
						if (ext_keep_s) s = tm;
						eval_all(m, s, ackp, cline_q, intr);
					end
				end
			end
		endcase
		m_d = m;
		s_d = s;
		ackp_d = ackp;
		intr_d = intr;
		lvec_d = lvec;
		st_d = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbase_q <= cicp_pkg::MASTER_BASE_RST;
			sbase_q <= cicp_pkg::SLAVE_BASE_RST;
			cline_q <= cicp_pkg::CASCADE_LINE_RST;
			m_q <= cicp_pkg::unit_reset();
			s_q <= cicp_pkg::unit_reset();
			ackp_q <= 1'b0;
			intr_q <= 1'b0;
			lvec_q <= 8'h00;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					cicp_pkg::REG_MASTER_BASE:  mbase_q <= cfg_data;
					cicp_pkg::REG_SLAVE_BASE:   sbase_q <= cfg_data;
					cicp_pkg::REG_CASCADE_LINE: cline_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (take) begin
				m_q <= m_d;
				s_q <= s_d;
				ackp_q <= ackp_d;
				intr_q <= intr_d;
				lvec_q <= lvec_d;
				out_valid <= 1'b1;
			end else if (out_ready) out_valid <= 1'b0;
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (take) begin
			status <= st_d;
			read_data <= rd_d;
			vector_out <= vec_d;
			vector_valid <= vv_d;
			interrupt_request <= intr_d;
		end
	end
endmodule
`default_nettype wire
